// ===== sv/pane_border_cell_classifier_unit_macros.svh =====
// Assertion macros for the pane border classifier
`ifndef PANE_BORDER_CELL_CLASSIFIER_UNIT_MACROS_SVH
`define PANE_BORDER_CELL_CLASSIFIER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define PBC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pbc check failed");
// next-cycle implication
`define PBC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pbc check failed");
`else
`define PBC_ASSERT_IMP(label, ante, cons)
`define PBC_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== sv/pbc_pkg.sv =====
`default_nettype none
package pbc_pkg;

  localparam int unsigned MaxPanesDef  = 8;
  localparam int unsigned CoordBitsDef = 10;
  localparam int unsigned NumPoints    = 5;  // center, left, right, up, down
  localparam int unsigned PtC = 0;
  localparam int unsigned PtL = 1;
  localparam int unsigned PtR = 2;
  localparam int unsigned PtU = 3;
  localparam int unsigned PtD = 4;

  localparam logic [3:0] CellInside  = 4'd0;
  localparam logic [3:0] CellOutside = 4'd12;

  localparam logic ReqWrite    = 1'b0;
  localparam logic ReqClassify = 1'b1;

  localparam logic [2:0] RegWidth  = 3'd0;
  localparam logic [2:0] RegHeight = 3'd4;

  // per-item control carried down the pipe
  typedef struct packed {
    logic valid;
    logic out_win;
    logic left_edge;
    logic top_edge;
  } pbc_ctl_t;

  // neighbor pattern {left,right,up,down} to cell kind
  function automatic logic [3:0] kind_of_pattern(input logic [3:0] pat);
    logic [3:0] k;
    case (pat)
      4'd3:    k = 4'd1;
      4'd5:    k = 4'd3;
      4'd6:    k = 4'd5;
      4'd7:    k = 4'd9;
      4'd9:    k = 4'd4;
      4'd10:   k = 4'd6;
      4'd11:   k = 4'd10;
      4'd12:   k = 4'd2;
      4'd13:   k = 4'd7;
      4'd14:   k = 4'd8;
      4'd15:   k = 4'd11;
      default: k = CellOutside;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== sv/pbc_pane_match.sv =====
`default_nettype none
// Pane table plus per-pane hit tests for the five probe points (stage 2)
module pbc_pane_match import pbc_pkg::*; #(
  parameter int unsigned MaxPanes  = MaxPanesDef,
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 adv_i,
  input  wire pbc_ctl_t             ctl_i,
  input  wire logic                 wr_en_i,
  input  wire logic [2:0]           wr_slot_i,
  input  wire logic                 wr_vis_i,
  input  wire logic [CoordBits-1:0] wr_x_i,
  input  wire logic [CoordBits-1:0] wr_y_i,
  input  wire logic [CoordBits-1:0] wr_w_i,
  input  wire logic [CoordBits-1:0] wr_h_i,
  input  wire logic [CoordBits:0]   px_i [NumPoints],
  input  wire logic [CoordBits:0]   py_i [NumPoints],
  output pbc_ctl_t                  ctl_o,
  output logic [MaxPanes-1:0]       hit_o  [NumPoints],
  output logic [MaxPanes-1:0]       bval_o [NumPoints],
  output logic                      near_o
);

  localparam int unsigned IdxW = (MaxPanes > 1) ? $clog2(MaxPanes) : 1;
  localparam int unsigned CW   = CoordBits + 1;

  logic [MaxPanes-1:0] vis_q;
  logic [CW-1:0]       x_q [MaxPanes];
  logic [CW-1:0]       y_q [MaxPanes];
  logic [CW-1:0]       r_q [MaxPanes];
  logic [CW-1:0]       b_q [MaxPanes];

  logic [5:0]    slot_ext;
  logic          slot_ok;
  logic [IdxW-1:0] slot_idx;

  assign slot_ext = {3'b000, wr_slot_i};
  assign slot_ok  = (32'(slot_ext) < MaxPanes);
  assign slot_idx = slot_ext[IdxW-1:0];

  // table write, in order with classify items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vis_q <= '0;
    end else if (wr_en_i && slot_ok) begin
      vis_q[slot_idx] <= wr_vis_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && slot_ok) begin
      x_q[slot_idx] <= {1'b0, wr_x_i};
      y_q[slot_idx] <= {1'b0, wr_y_i};
      r_q[slot_idx] <= {1'b0, wr_x_i} + {1'b0, wr_w_i};
      b_q[slot_idx] <= {1'b0, wr_y_i} + {1'b0, wr_h_i};
    end
  end

  // containment and frame tests
  logic [MaxPanes-1:0] hit_d  [NumPoints];
  logic [MaxPanes-1:0] bval_d [NumPoints];
  logic [MaxPanes-1:0] near_vec;

  always_comb begin
    logic [CW-1:0] px1, py1;
    logic contain, vert, horz, xz, yz;
    for (int p = 0; p < NumPoints; p++) begin
      px1 = px_i[p] + CW'(1);
      py1 = py_i[p] + CW'(1);
      for (int i = 0; i < MaxPanes; i++) begin
        xz      = (x_q[i] == '0);
        yz      = (y_q[i] == '0);
        contain = (px_i[p] >= x_q[i]) && (px_i[p] < r_q[i]) &&
                  (py_i[p] >= y_q[i]) && (py_i[p] < b_q[i]);
        vert    = (yz || py1 >= y_q[i]) && (py_i[p] <= b_q[i]) &&
                  ((!xz && px1 == x_q[i]) || px_i[p] == r_q[i]);
        horz    = (xz || px1 >= x_q[i]) && (px_i[p] <= r_q[i]) &&
                  ((!yz && py1 == y_q[i]) || py_i[p] == b_q[i]);
        hit_d[p][i]  = vis_q[i] && (contain || vert || horz);
        bval_d[p][i] = !contain;
      end
    end
    for (int i = 0; i < MaxPanes; i++) begin
      px1 = px_i[PtC] + CW'(1);
      py1 = py_i[PtC] + CW'(1);
      near_vec[i] = vis_q[i] &&
                    !((x_q[i] != '0 && px1 < x_q[i]) || px_i[PtC] > r_q[i] ||
                      (y_q[i] != '0 && py1 < y_q[i]) || py_i[PtC] > b_q[i]);
    end
  end

  // stage 2 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else if (adv_i) begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      hit_o  <= hit_d;
      bval_o <= bval_d;
      near_o <= |near_vec;
    end
  end

endmodule
`default_nettype wire

// ===== sv/pbc_kind.sv =====
`default_nettype none
// Priority resolve of border tests and kind lookup (stage 3, output register)
module pbc_kind import pbc_pkg::*; #(
  parameter int unsigned MaxPanes = MaxPanesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                adv_i,
  input  wire pbc_ctl_t            ctl_i,
  input  wire logic [MaxPanes-1:0] hit_i  [NumPoints],
  input  wire logic [MaxPanes-1:0] bval_i [NumPoints],
  input  wire logic                near_i,
  output logic                     valid_o,
  output logic [3:0]               kind_o
);

  logic [NumPoints-1:0] border;
  logic [3:0]           pat;
  logic [3:0]           kind_d;

  // lowest slot that hits decides each point
  always_comb begin
    for (int p = 0; p < NumPoints; p++) begin
      border[p] = 1'b0;
      for (int i = MaxPanes - 1; i >= 0; i--) begin
        if (hit_i[p][i]) begin
          border[p] = bval_i[p][i];
        end
      end
    end
  end

  assign pat = {ctl_i.left_edge | border[PtL], border[PtR],
                ctl_i.top_edge  | border[PtU], border[PtD]};

  always_comb begin
    if (ctl_i.out_win || !near_i) begin
      kind_d = CellOutside;
    end else if (!border[PtC]) begin
      kind_d = CellInside;
    end else begin
      kind_d = kind_of_pattern(pat);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (adv_i) begin
      valid_o <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      kind_o <= kind_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/pane_border_cell_classifier_unit.sv =====
`default_nettype none
// Pane border cell classifier. Three register stages (input and probe points,
// pane table match, priority resolve into the output register); one item
// enters per clock unless held. Pane writes take effect at the table stage,
// in order with classify items, and yield no result. The whole pipe holds
// while a result waits under out_stall_i. Window size registers: width at
// 0x0, height at 0x4.
`include "pane_border_cell_classifier_unit_macros.svh"
module pane_border_cell_classifier_unit import pbc_pkg::*; #(
  parameter int unsigned MaxPanes  = MaxPanesDef,
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 req_type_i,
  input  wire logic [2:0]           pane_slot_i,
  input  wire logic                 pane_visible_i,
  input  wire logic [CoordBits-1:0] pane_x_i,
  input  wire logic [CoordBits-1:0] pane_y_i,
  input  wire logic [CoordBits-1:0] pane_w_i,
  input  wire logic [CoordBits-1:0] pane_h_i,
  input  wire logic [CoordBits-1:0] cell_x_i,
  input  wire logic [CoordBits-1:0] cell_y_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [3:0]                cell_kind_o
);

  localparam int unsigned CW = CoordBits + 1;

  // config registers
  logic [CoordBits-1:0] win_w_q, win_h_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_w_q <= CoordBits'(80);
      win_h_q <= CoordBits'(24);
    end else if (cfg_wr) begin
      if (paddr[2] == RegHeight[2]) begin
        win_h_q <= pwdata[CoordBits-1:0];
      end else begin
        win_w_q <= pwdata[CoordBits-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == RegHeight[2]) begin
      prdata = 32'(win_h_q);
    end else begin
      prdata = 32'(win_w_q);
    end
  end

  // global advance
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // stage 1: item and probe points
  logic                 s1_valid_q, s1_cls_q;
  logic [2:0]           s1_slot_q;
  logic                 s1_vis_q;
  logic [CoordBits-1:0] s1_x_q, s1_y_q, s1_w_q, s1_h_q;
  logic [CoordBits-1:0] s1_cx_q, s1_cy_q;
  logic [CoordBits-1:0] s1_ww_q, s1_wh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      s1_cls_q  <= (req_type_i == ReqClassify);
      s1_slot_q <= pane_slot_i;
      s1_vis_q  <= pane_visible_i;
      s1_x_q    <= pane_x_i;
      s1_y_q    <= pane_y_i;
      s1_w_q    <= pane_w_i;
      s1_h_q    <= pane_h_i;
      s1_cx_q   <= cell_x_i;
      s1_cy_q   <= cell_y_i;
      s1_ww_q   <= win_w_q;
      s1_wh_q   <= win_h_q;
    end
  end

  logic [CW-1:0] px [NumPoints];
  logic [CW-1:0] py [NumPoints];
  pbc_ctl_t      s1_ctl;
  logic [CW-1:0] cx_e, cy_e;

  assign cx_e = {1'b0, s1_cx_q};
  assign cy_e = {1'b0, s1_cy_q};

  always_comb begin
    px[PtC] = cx_e;           py[PtC] = cy_e;
    px[PtL] = cx_e - CW'(1);  py[PtL] = cy_e;
    px[PtR] = cx_e + CW'(1);  py[PtR] = cy_e;
    px[PtU] = cx_e;           py[PtU] = cy_e - CW'(1);
    px[PtD] = cx_e;           py[PtD] = cy_e + CW'(1);
    s1_ctl.valid     = s1_valid_q && s1_cls_q;
    s1_ctl.out_win   = (s1_cx_q > s1_ww_q) || (s1_cy_q > s1_wh_q);
    s1_ctl.left_edge = (s1_cx_q == '0);
    s1_ctl.top_edge  = (s1_cy_q == '0);
  end

  // stage 2
  pbc_ctl_t            s2_ctl;
  logic [MaxPanes-1:0] s2_hit  [NumPoints];
  logic [MaxPanes-1:0] s2_bval [NumPoints];
  logic                s2_near;
  logic                tbl_wr;

  assign tbl_wr = adv && s1_valid_q && !s1_cls_q;

  pbc_pane_match #(
    .MaxPanes (MaxPanes),
    .CoordBits(CoordBits)
  ) u_match (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .ctl_i    (s1_ctl),
    .wr_en_i  (tbl_wr),
    .wr_slot_i(s1_slot_q),
    .wr_vis_i (s1_vis_q),
    .wr_x_i   (s1_x_q),
    .wr_y_i   (s1_y_q),
    .wr_w_i   (s1_w_q),
    .wr_h_i   (s1_h_q),
    .px_i     (px),
    .py_i     (py),
    .ctl_o    (s2_ctl),
    .hit_o    (s2_hit),
    .bval_o   (s2_bval),
    .near_o   (s2_near)
  );

  // stage 3
  pbc_kind #(
    .MaxPanes(MaxPanes)
  ) u_kind (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .ctl_i  (s2_ctl),
    .hit_i  (s2_hit),
    .bval_i (s2_bval),
    .near_i (s2_near),
    .valid_o(out_valid_o),
    .kind_o (cell_kind_o)
  );

  // checks
  `PBC_ASSERT_NXT(a_hold_valid, out_valid_o && out_stall_i, out_valid_o)
  `PBC_ASSERT_NXT(a_hold_kind, out_valid_o && out_stall_i, $stable(cell_kind_o))
  `PBC_ASSERT_IMP(a_kind_range, out_valid_o, cell_kind_o <= CellOutside)
  `PBC_ASSERT_NXT(a_write_silent, s1_valid_q && !s1_cls_q && adv, !s2_ctl.valid)

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import pbc_pkg::*;

  // cell kinds as the block reports them
  localparam logic [3:0] KindVert  = 4'd1;
  localparam logic [3:0] KindHoriz = 4'd2;
  localparam logic [3:0] KindTL    = 4'd3;
  localparam logic [3:0] KindTR    = 4'd4;
  localparam logic [3:0] KindBL    = 4'd5;
  localparam logic [3:0] KindBR    = 4'd6;
  localparam logic [3:0] KindTeeT  = 4'd7;
  localparam logic [3:0] KindTeeB  = 4'd8;
  localparam logic [3:0] KindTeeL  = 4'd9;
  localparam logic [3:0] KindTeeR  = 4'd10;
  localparam logic [3:0] KindCross = 4'd11;
  localparam int PipeDepth = 3;

  typedef struct packed {
    logic       req;
    logic [2:0] slot;
    logic       vis;
    logic [9:0] px, py, pw, ph;
    logic [9:0] cx, cy;
  } pane_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic req_type_i = 1'b0;
  logic [2:0] pane_slot_i = '0;
  logic pane_visible_i = 1'b0;
  logic [9:0] pane_x_i = '0, pane_y_i = '0, pane_w_i = '0, pane_h_i = '0;
  logic [9:0] cell_x_i = '0, cell_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [3:0] cell_kind_o;

  pane_border_cell_classifier_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // shadow of the pane table and window registers
  bit          shd_vis [8];
  int unsigned shd_x [8], shd_y [8], shd_w [8], shd_h [8];
  int unsigned win_w = 80, win_h = 24;

  pane_req_t   pending_q [$];
  logic [3:0]  kind_q [$];
  int          err_cnt = 0;
  int          gap_left = 0;
  int          res_wait = 0;
  int          hold_cycles = 0;
  bit          hold_req = 1'b0;

  task automatic report(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    err_cnt++;
  endtask

  function automatic bit frame_hit(int unsigned cx, int unsigned cy);
    int unsigned x, y, r, b;
    for (int i = 0; i < 8; i++) begin
      if (!shd_vis[i]) continue;
      x = shd_x[i]; y = shd_y[i]; r = x + shd_w[i]; b = y + shd_h[i];
      if (cx >= x && cx < r && cy >= y && cy < b) return 1'b0;
      if ((y == 0 || cy + 1 >= y) && cy <= b) begin
        if (x != 0 && cx + 1 == x) return 1'b1;
        if (cx == r) return 1'b1;
      end
      if ((x == 0 || cx + 1 >= x) && cx <= r) begin
        if (y != 0 && cy + 1 == y) return 1'b1;
        if (cy == b) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // pattern bits: left, right, up, down
  function automatic logic [3:0] pattern_kind(logic [3:0] pat);
    case (pat)
      4'b0011: return KindVert;
      4'b1100: return KindHoriz;
      4'b0101: return KindTL;
      4'b1001: return KindTR;
      4'b0110: return KindBL;
      4'b1010: return KindBR;
      4'b1101: return KindTeeT;
      4'b1110: return KindTeeB;
      4'b0111: return KindTeeL;
      4'b1011: return KindTeeR;
      4'b1111: return KindCross;
      default: return CellOutside;
    endcase
  endfunction

  function automatic logic [3:0] cell_kind_of(int unsigned cx, int unsigned cy);
    logic [3:0] pat, k;
    int unsigned x, y;
    if (cx > win_w || cy > win_h) return CellOutside;
    for (int i = 0; i < 8; i++) begin
      if (!shd_vis[i]) continue;
      x = shd_x[i]; y = shd_y[i];
      if ((x != 0 && cx + 1 < x) || cx > x + shd_w[i] ||
          (y != 0 && cy + 1 < y) || cy > y + shd_h[i]) continue;
      if (!frame_hit(cx, cy)) return CellInside;
      pat[3] = (cx == 0) || frame_hit(cx - 1, cy);
      pat[2] = (cx <= win_w) && frame_hit(cx + 1, cy);
      pat[1] = (cy == 0) || frame_hit(cx, cy - 1);
      pat[0] = (cy <= win_h) && frame_hit(cx, cy + 1);
      k = pattern_kind(pat);
      if (k != CellOutside) return k;
    end
    return CellOutside;
  endfunction

  // apply one accepted transfer to the shadow table or queue its kind
  task automatic predict(input pane_req_t it);
    if (it.req == ReqWrite) begin
      shd_vis[it.slot] = it.vis;
      shd_x[it.slot] = it.px; shd_y[it.slot] = it.py;
      shd_w[it.slot] = it.pw; shd_h[it.slot] = it.ph;
    end else begin
      kind_q.push_back(cell_kind_of(it.cx, it.cy));
    end
  endtask

  // driver: one item per transfer, random gap between items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o)
        predict({req_type_i, pane_slot_i, pane_visible_i, pane_x_i, pane_y_i,
                 pane_w_i, pane_h_i, cell_x_i, cell_y_i});
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          pane_req_t it;
          it = pending_q.pop_front();
          {req_type_i, pane_slot_i, pane_visible_i, pane_x_i, pane_y_i,
           pane_w_i, pane_h_i, cell_x_i, cell_y_i} <= it;
          in_valid_i <= 1'b1;
          gap_left <= $urandom_range(0, 3);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transfer, then draw the next stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (res_wait > 0) res_wait--;
      if (out_valid_o && !out_stall_i) begin
        if (kind_q.size() == 0)
          report($sformatf("unexpected result kind %0d", cell_kind_o));
        else begin
          logic [3:0] want;
          want = kind_q.pop_front();
          if (cell_kind_o !== want)
            report($sformatf("cell_kind got %0d want %0d", cell_kind_o, want));
        end
        res_wait = $urandom_range(0, 3);
      end
      out_stall_i <= hold_cycles > 0 || res_wait > 0;
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (hold_req && hold_cycles == 0) begin
      hold_cycles <= 300;
      hold_req <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == RegWidth) win_w = data[9:0]; else win_h = data[9:0];
  endtask

  task automatic wait_idle();
    while (pending_q.size() > 0 || in_valid_i || kind_q.size() > 0)
      @(posedge clk_i);
    repeat (PipeDepth + 4) @(posedge clk_i);
  endtask

  function automatic pane_req_t pane_wr(int s, bit v, int x, int y, int w, int h);
    pane_req_t it;
    it = '{req: ReqWrite, slot: 3'(s), vis: v, px: 10'(x), py: 10'(y),
           pw: 10'(w), ph: 10'(h), cx: 10'($urandom), cy: 10'($urandom)};
    return it;
  endfunction

  function automatic pane_req_t cell_rd(int x, int y);
    pane_req_t it;
    it = '{req: ReqClassify, slot: 3'($urandom), vis: 1'($urandom),
           px: 10'($urandom), py: 10'($urandom), pw: 10'($urandom),
           ph: 10'($urandom), cx: 10'(x), cy: 10'(y)};
    return it;
  endfunction

  // random phase: mostly cells near pane frames, some pane rewrites and noise
  task automatic fill_random(input int n);
    pane_req_t it;
    int j, r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        it = pane_wr($urandom_range(0, 7), $urandom_range(0, 5) != 0,
                     $urandom_range(0, win_w), $urandom_range(0, win_h),
                     $urandom_range(1, 20), $urandom_range(1, 12));
        if ($urandom_range(0, 15) == 0) it.px = 10'($urandom);
        if ($urandom_range(0, 15) == 0) it.pw = 10'($urandom);
        if ($urandom_range(0, 15) == 0) it.py = 10'($urandom);
        if ($urandom_range(0, 15) == 0) it.ph = 10'($urandom);
      end else if (r < 30) begin
        it = cell_rd($urandom, $urandom);
      end else begin
        j = $urandom_range(0, 7);
        it = cell_rd(shd_x[j] + $urandom_range(0, shd_w[j] + 2) - 1,
                     shd_y[j] + $urandom_range(0, shd_h[j] + 2) - 1);
      end
      pending_q.push_back(it);
    end
  endtask

  // directed opening items; pane fields mirror the shadow only at writes
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    pending_q.push_back(cell_rd(0, 0));                 // no pane near
    pending_q.push_back(pane_wr(0, 1, 0, 0, 10, 5));    // pane at screen corner
    pending_q.push_back(pane_wr(1, 1, 11, 0, 20, 5));   // neighbor to the right
    pending_q.push_back(pane_wr(2, 1, 0, 6, 31, 6));    // pane below both
    pending_q.push_back(pane_wr(3, 0, 40, 3, 5, 5));    // invisible
    pending_q.push_back(pane_wr(4, 1, 50, 10, 0, 0));   // zero size, frame only
    pending_q.push_back(pane_wr(7, 1, 1023, 1023, 1023, 1023));
    pending_q.push_back(cell_rd(3, 3));
    pending_q.push_back(cell_rd(10, 2));
    pending_q.push_back(cell_rd(10, 5));
    pending_q.push_back(cell_rd(5, 5));
    pending_q.push_back(cell_rd(31, 5));
    pending_q.push_back(cell_rd(31, 12));
    pending_q.push_back(cell_rd(0, 12));
    pending_q.push_back(cell_rd(50, 10));
    pending_q.push_back(cell_rd(49, 9));
    pending_q.push_back(cell_rd(42, 4));
    pending_q.push_back(cell_rd(80, 24));               // at window edge
    pending_q.push_back(cell_rd(81, 5));                // beyond width
    pending_q.push_back(cell_rd(5, 25));                // beyond height
    pending_q.push_back(cell_rd(1023, 1023));
    pending_q.push_back(cell_rd(40, 12));
    fill_random(200);
    wait_idle();
    apb_write(RegWidth, 1023); apb_write(RegHeight, 1023);
    hold_req = 1'b1;
    fill_random(220);
    wait_idle();
    apb_write(RegWidth, 1); apb_write(RegHeight, 1);
    fill_random(180);
    wait_idle();
    apb_write(RegWidth, 40); apb_write(RegHeight, 12);
    fill_random(200);
    wait_idle();
    apb_write(RegWidth, $urandom_range(1, 1023));
    apb_write(RegHeight, $urandom_range(1, 1023));
    hold_req = 1'b1;
    fill_random(200);
    wait_idle();
    apb_write(RegWidth, 80); apb_write(RegHeight, 24);
    fill_random(100);
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0 && kind_q.size() == 0)
      $display("pane_border_cell_classifier_unit: match");
    else
      $display("pane_border_cell_classifier_unit: mismatch");
    $finish;
  end

  initial begin
    #3000000;
    $display("pane_border_cell_classifier_unit: mismatch");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/pbc_pkg.sv
sv/pbc_pane_match.sv
sv/pbc_kind.sv
sv/pane_border_cell_classifier_unit.sv
bench/tb_top.sv
